@@ sv/arq_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// arq_pkg
// Shared types and codes for the retransmit table: operation codes, result
// kinds and the command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package arq_pkg;

    localparam int IdW    = 32;
    localparam int KindW  = 3;
    localparam int SlotW  = 4;
    localparam int NresW  = 5;
    localparam logic [NresW-1:0] ResultLimit = 5'd16;

    typedef enum logic [1:0] {
        F_SEND = 2'd0,
        F_ACK  = 2'd1,
        F_TICK = 2'd2
    } t_func;

    typedef enum logic [KindW-1:0] {
        K_SENT    = 3'd0,
        K_RETX    = 3'd1,
        K_FULL    = 3'd2,
        K_ACKED   = 3'd3,
        K_UNKNOWN = 3'd4
    } t_kind;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_INIT_SEND,
        OP_INIT_ACK,
        OP_INIT_TICK,
        OP_SEND_STEP,
        OP_ACK_STEP,
        OP_TICK_STEP,
        OP_TICK_END
    } t_op;

    typedef struct packed {
        t_op op;
    } t_cmd;

    typedef struct packed {
        logic send_done;
        logic ack_done;
        logic tick_done;
    } t_stat;

endpackage

`default_nettype wire

@@ sv/arq_dpath.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// arq_dpath
// Slot table datapath: valid bits, id and stamp memories, counters, the
// one-slot-per-cycle scan and the result registers.
// ----------------------------------------------------------------------------
module arq_dpath
    import arq_pkg::*;
#(
    parameter int TABLE_ENTRIES = 16
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire t_cmd             i_cmd,
    input  wire logic [IdW-1:0]   i_ack_id,
    input  wire logic [7:0]       i_timeout,
    output t_stat                 o_stat,
    output logic                  o_strobe,
    output logic [KindW-1:0]      o_kind,
    output logic [IdW-1:0]        o_msg_id,
    output logic [SlotW-1:0]      o_slot,
    output logic [IdW-1:0]        o_transmit_count,
    output logic                  o_last
);

    localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CW = $clog2(TABLE_ENTRIES + 1);

    // table storage
    logic [TABLE_ENTRIES-1:0] r_valid;
    logic [IdW-1:0]           mem_id    [TABLE_ENTRIES];
    logic [IdW-1:0]           mem_stamp [TABLE_ENTRIES];

    logic [IdW-1:0]   r_next_id;
    logic [IdW-1:0]   r_now;
    logic [IdW-1:0]   r_sends;
    logic [IdW-1:0]   r_ack_id;

    // scan pointer and check stage
    logic [CW-1:0]    r_scan;
    logic             r_chk_vld;
    logic [IW-1:0]    r_chk_idx;
    logic [IdW-1:0]   r_rd_id;
    logic [IdW-1:0]   r_rd_stamp;
    logic [NresW-1:0] r_nres;

    // pending retransmit, held until we know whether it is the last one
    logic             r_pend_vld;
    logic [IdW-1:0]   r_pend_id;
    logic [SlotW-1:0] r_pend_slot;
    logic [IdW-1:0]   r_pend_cnt;

    logic             r_strobe;
    t_kind            r_out_kind;
    logic [IdW-1:0]   r_out_id;
    logic [SlotW-1:0] r_out_slot;
    logic [IdW-1:0]   r_out_cnt;
    logic             r_out_last;

    logic             scan_end;
    logic [IW-1:0]    scan_idx;
    logic             free;
    logic             rd_en;
    logic [IdW-1:0]   age;
    logic             chk_live;
    logic             ack_hit;
    logic             due;
    logic             chk_drained;

    assign scan_end    = (r_scan == CW'(TABLE_ENTRIES));
    assign scan_idx    = r_scan[IW-1:0];
    assign free        = !scan_end && !r_valid[scan_idx];
    assign rd_en       = ((i_cmd.op == OP_ACK_STEP) || (i_cmd.op == OP_TICK_STEP)) && !scan_end;
    assign age         = r_now - r_rd_stamp;
    assign chk_live    = r_chk_vld && r_valid[r_chk_idx];
    assign ack_hit     = chk_live && (r_rd_id == r_ack_id);
    assign due         = chk_live && (age >= {24'd0, i_timeout});
    assign chk_drained = !r_chk_vld && scan_end;

    assign o_stat.send_done = free || scan_end;
    assign o_stat.ack_done  = ack_hit || chk_drained;
    assign o_stat.tick_done = chk_drained || (r_nres == ResultLimit);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_next_id  <= '0;
            r_now      <= '0;
            r_sends    <= '0;
            r_scan     <= '0;
            r_chk_vld  <= 1'b0;
            r_nres     <= '0;
            r_pend_vld <= 1'b0;
            r_strobe   <= 1'b0;
        end else begin
            r_strobe <= 1'b0;
            unique case (i_cmd.op)
                OP_NONE: begin
                end
                OP_INIT_SEND: begin
                    r_next_id <= r_next_id + 1'b1;
                    r_scan    <= '0;
                end
                OP_INIT_ACK: begin
                    r_scan    <= '0;
                    r_chk_vld <= 1'b0;
                end
                OP_INIT_TICK: begin
                    r_now      <= r_now + 1'b1;
                    r_scan     <= '0;
                    r_chk_vld  <= 1'b0;
                    r_nres     <= '0;
                    r_pend_vld <= 1'b0;
                end
                OP_SEND_STEP: begin
                    if (free) begin
                        r_valid[scan_idx] <= 1'b1;
                        r_sends           <= r_sends + 1'b1;
                        r_strobe          <= 1'b1;
                    end else if (scan_end) begin
                        r_strobe <= 1'b1;
                    end else begin
                        r_scan <= r_scan + 1'b1;
                    end
                end
                OP_ACK_STEP: begin
                    r_chk_vld <= rd_en;
                    if (rd_en) begin
                        r_scan <= r_scan + 1'b1;
                    end
                    if (ack_hit) begin
                        r_valid[r_chk_idx] <= 1'b0;
                        r_strobe           <= 1'b1;
                    end else if (chk_drained) begin
                        r_strobe <= 1'b1;
                    end
                end
                OP_TICK_STEP: begin
                    r_chk_vld <= rd_en;
                    if (rd_en) begin
                        r_scan <= r_scan + 1'b1;
                    end
                    if (due) begin
                        r_sends    <= r_sends + 1'b1;
                        r_nres     <= r_nres + 1'b1;
                        r_pend_vld <= 1'b1;
                        r_strobe   <= r_pend_vld;
                    end
                end
                OP_TICK_END: begin
                    r_strobe   <= r_pend_vld;
                    r_pend_vld <= 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_id    <= mem_id[scan_idx];
            r_rd_stamp <= mem_stamp[scan_idx];
        end
        if (rd_en || (i_cmd.op == OP_INIT_ACK) || (i_cmd.op == OP_INIT_TICK)) begin
            r_chk_idx <= scan_idx;
        end
        unique case (i_cmd.op)
            OP_NONE, OP_INIT_SEND, OP_INIT_TICK: begin
            end
            OP_INIT_ACK: begin
                r_ack_id <= i_ack_id;
            end
            OP_SEND_STEP: begin
                r_out_id   <= r_next_id;
                r_out_last <= 1'b1;
                if (free) begin
                    mem_id[scan_idx]    <= r_next_id;
                    mem_stamp[scan_idx] <= r_now;
                    r_out_kind          <= K_SENT;
                    r_out_slot          <= SlotW'(scan_idx);
                    r_out_cnt           <= r_sends + 1'b1;
                end else begin
                    r_out_kind <= K_FULL;
                    r_out_slot <= '0;
                    r_out_cnt  <= r_sends;
                end
            end
            OP_ACK_STEP: begin
                r_out_id   <= r_ack_id;
                r_out_cnt  <= r_sends;
                r_out_last <= 1'b1;
                if (ack_hit) begin
                    r_out_kind <= K_ACKED;
                    r_out_slot <= SlotW'(r_chk_idx);
                end else begin
                    r_out_kind <= K_UNKNOWN;
                    r_out_slot <= '0;
                end
            end
            OP_TICK_STEP: begin
                if (due) begin
                    mem_stamp[r_chk_idx] <= r_now;
                    r_pend_id            <= r_rd_id;
                    r_pend_slot          <= SlotW'(r_chk_idx);
                    r_pend_cnt           <= r_sends + 1'b1;
                    // the earlier retransmit is now known not to be the last
                    r_out_kind           <= K_RETX;
                    r_out_id             <= r_pend_id;
                    r_out_slot           <= r_pend_slot;
                    r_out_cnt            <= r_pend_cnt;
                    r_out_last           <= 1'b0;
                end
            end
            OP_TICK_END: begin
                r_out_kind <= K_RETX;
                r_out_id   <= r_pend_id;
                r_out_slot <= r_pend_slot;
                r_out_cnt  <= r_pend_cnt;
                r_out_last <= 1'b1;
            end
        endcase
    end

    assign o_strobe         = r_strobe;
    assign o_kind           = r_out_kind;
    assign o_msg_id         = r_out_id;
    assign o_slot           = r_out_slot;
    assign o_transmit_count = r_out_cnt;
    assign o_last           = r_out_last;

endmodule

`default_nettype wire

@@ sv/arq_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// arq_ctrl
// Sequencer for the retransmit table: decodes the operation and steps the
// datapath scan until it reports completion.
// ----------------------------------------------------------------------------
module arq_ctrl
    import arq_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_start,
    input  wire logic [1:0] i_func,
    input  wire t_stat      i_stat,
    output t_cmd            o_cmd,
    output logic            o_busy
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SEND,
        S_ACK,
        S_TICK
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state  = r_state;
        o_cmd.op = OP_NONE;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    unique case (i_func)
                        F_SEND: begin
                            o_cmd.op = OP_INIT_SEND;
                            n_state  = S_SEND;
                        end
                        F_ACK: begin
                            o_cmd.op = OP_INIT_ACK;
                            n_state  = S_ACK;
                        end
                        F_TICK: begin
                            o_cmd.op = OP_INIT_TICK;
                            n_state  = S_TICK;
                        end
                        default: begin
                            // undefined operation: no effect
                        end
                    endcase
                end
            end
            S_SEND: begin
                o_cmd.op = OP_SEND_STEP;
                if (i_stat.send_done) begin
                    n_state = S_IDLE;
                end
            end
            S_ACK: begin
                o_cmd.op = OP_ACK_STEP;
                if (i_stat.ack_done) begin
                    n_state = S_IDLE;
                end
            end
            S_TICK: begin
                if (i_stat.tick_done) begin
                    o_cmd.op = OP_TICK_END;
                    n_state  = S_IDLE;
                end else begin
                    o_cmd.op = OP_TICK_STEP;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

`default_nettype wire

@@ sv/arq_retransmit_table.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// arq_retransmit_table
// Sender-side retransmission timer table with an APB register for the
// timeout.
// ----------------------------------------------------------------------------
// An operation is taken when start is high and busy is low; the table is
// walked one slot per cycle through the id/stamp memory port. A send ends
// early when a low slot is free, and a tick stops early once 16 retransmits
// are found; an undefined operation code is taken and does nothing. Every
// result is a one-cycle pulse on o_strobe with no back-pressure, so the
// receiver must take each beat as it comes. Retransmits of a tick come out
// while the scan runs, each one delayed until the next due entry is found,
// and the final beat carries o_last. At most 16 retransmits are issued per
// tick.
// ----------------------------------------------------------------------------
module arq_retransmit_table
    import arq_pkg::*;
#(
    parameter int TABLE_ENTRIES = 16
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             start,
    output logic                  busy,
    input  wire logic [1:0]       i_func,
    input  wire logic [IdW-1:0]   i_ack_id,
    output logic                  o_strobe,
    output logic [KindW-1:0]      o_kind,
    output logic [IdW-1:0]        o_msg_id,
    output logic [SlotW-1:0]      o_slot,
    output logic [IdW-1:0]        o_transmit_count,
    output logic                  o_last,
    input  wire logic             psel,
    input  wire logic             penable,
    input  wire logic             pwrite,
    input  wire logic [2:0]       paddr,
    input  wire logic [31:0]      pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    logic  [7:0] r_timeout;
    logic        reg_sel;
    t_cmd        cmd;
    t_stat       stat;

    // only the timeout register exists; it answers at any address with paddr[2] low (0 to 3)
    assign reg_sel = (paddr[2] == 1'b0);
    assign pready  = 1'b1;
    assign prdata  = reg_sel ? {24'd0, r_timeout} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout <= 8'd2;
        end else if (psel && penable && pwrite && reg_sel) begin
            r_timeout <= pwdata[7:0];
        end
    end

    arq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_func  (i_func),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    arq_dpath #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_dpath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .i_ack_id         (i_ack_id),
        .i_timeout        (r_timeout),
        .o_stat           (stat),
        .o_strobe         (o_strobe),
        .o_kind           (o_kind),
        .o_msg_id         (o_msg_id),
        .o_slot           (o_slot),
        .o_transmit_count (o_transmit_count),
        .o_last           (o_last)
    );

    // a beat that is not the last one only comes out mid-tick
    a_midtick_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_last |-> busy)
        else $error("non-final result while idle");

    // table full, acked and unknown-id results give a single beat
    a_single_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && (o_kind == K_FULL || o_kind == K_ACKED || o_kind == K_UNKNOWN)
        |-> o_last)
        else $error("single-result kind without last");

    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && (i_func == F_SEND || i_func == F_ACK || i_func == F_TICK)
        |=> busy)
        else $error("operation taken but block not busy");

endmodule

`default_nettype wire

@@ test/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the retransmit table. Sends, acks and ticks are
// queued in phases; every phase but the first has its own timeout written over
// APB while the table is idle. A clocked driver and monitor run the command
// handshake. The monitor keeps a copy of the slot table and predicts every
// result beat, then checks each strobed beat against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;
    import arq_pkg::*;

    localparam int NSLOTS = 16;
    localparam int MAX_RETX = 16;
    localparam logic [1:0] F_UNDEF = 2'd3;
    localparam logic [2:0] TIMEOUT_ADDR = 3'd0;
    localparam int SETTLE_CYCLES = 40;
    localparam int DRAIN_LIMIT = 5000;
    localparam int SHOWN_MAX = 10;
    localparam int PHASES = 6;
    localparam int PHASE_OPS = 15;

    typedef struct {
        logic [1:0]     func;
        logic [IdW-1:0] ack_id;
        int             gap;
    } op_item_t;

    typedef struct {
        logic [KindW-1:0] kind;
        logic [IdW-1:0]   msg_id;
        logic [SlotW-1:0] slot;
        logic [IdW-1:0]   count;
        logic             last;
    } beat_t;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             start = 1'b0;
    logic             busy;
    logic [1:0]       i_func = F_SEND;
    logic [IdW-1:0]   i_ack_id = '0;
    logic             o_strobe;
    logic [KindW-1:0] o_kind;
    logic [IdW-1:0]   o_msg_id;
    logic [SlotW-1:0] o_slot;
    logic [IdW-1:0]   o_transmit_count;
    logic             o_last;
    logic             psel = 1'b0;
    logic             penable = 1'b0;
    logic             pwrite = 1'b0;
    logic [2:0]       paddr = '0;
    logic [31:0]      pwdata = '0;
    logic [31:0]      prdata;
    logic             pready;

    arq_retransmit_table #(
        .TABLE_ENTRIES(NSLOTS)
    ) DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_func           (i_func),
        .i_ack_id         (i_ack_id),
        .o_strobe         (o_strobe),
        .o_kind           (o_kind),
        .o_msg_id         (o_msg_id),
        .o_slot           (o_slot),
        .o_transmit_count (o_transmit_count),
        .o_last           (o_last),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready)
    );

    always #10 i_clk = ~i_clk;

    // shadow of the slot table
    logic           tbl_valid [NSLOTS] = '{default: 1'b0};
    logic [IdW-1:0] tbl_id    [NSLOTS] = '{default: '0};
    logic [IdW-1:0] tbl_stamp [NSLOTS] = '{default: '0};
    logic [IdW-1:0] id_counter = '0;
    logic [IdW-1:0] tick_now = '0;
    logic [IdW-1:0] tx_total = '0;
    logic [7:0]     timeout_cfg = 8'd2;

    beat_t    expected_beats [$];
    op_item_t pending_ops [$];
    int       items_queued = 0;
    int       items_taken = 0;
    int       error_count = 0;
    bit       beat_taken = 1'b0;
    bit       steady = 1'b0;
    int       gap_left = 0;

    function automatic beat_t make_beat(input logic [KindW-1:0] kind,
                                        input logic [IdW-1:0] id,
                                        input int slot, input logic last);
        beat_t b;
        b.kind = kind;
        b.msg_id = id;
        b.slot = SlotW'(slot);
        b.count = tx_total;
        b.last = last;
        return b;
    endfunction

    function automatic bit slot_due(input int i);
        return tbl_valid[i] && ((tick_now - tbl_stamp[i]) >= {24'd0, timeout_cfg});
    endfunction

    function automatic string beat_str(input beat_t b);
        return $sformatf("kind %0d id %h slot %0d count %0d last %0d",
                         b.kind, b.msg_id, b.slot, b.count, b.last);
    endfunction

    task automatic note_mismatch(input string msg);
        if (error_count < SHOWN_MAX)
            $display("[%0t] mismatch: %s", $time, msg);
        error_count++;
    endtask

    // work out the beats one accepted command causes
    task automatic advance_table(input logic [1:0] func, input logic [IdW-1:0] aid);
        bit hit;
        int n_due;
        int n;
        hit = 1'b0;
        n_due = 0;
        n = 0;
        case (func)
            F_SEND: begin
                id_counter = id_counter + 1;
                for (int i = 0; i < NSLOTS; i++) begin
                    if (!hit && !tbl_valid[i]) begin
                        hit = 1'b1;
                        tbl_valid[i] = 1'b1;
                        tbl_id[i] = id_counter;
                        tbl_stamp[i] = tick_now;
                        tx_total = tx_total + 1;
                        expected_beats.push_back(make_beat(K_SENT, id_counter, i, 1'b1));
                    end
                end
                // table full still burns the id
                if (!hit)
                    expected_beats.push_back(make_beat(K_FULL, id_counter, 0, 1'b1));
            end
            F_ACK: begin
                for (int i = 0; i < NSLOTS; i++) begin
                    if (!hit && tbl_valid[i] && tbl_id[i] == aid) begin
                        hit = 1'b1;
                        tbl_valid[i] = 1'b0;
                        expected_beats.push_back(make_beat(K_ACKED, aid, i, 1'b1));
                    end
                end
                if (!hit)
                    expected_beats.push_back(make_beat(K_UNKNOWN, aid, 0, 1'b1));
            end
            F_TICK: begin
                tick_now = tick_now + 1;
                for (int i = 0; i < NSLOTS; i++)
                    if (slot_due(i) && n_due < MAX_RETX)
                        n_due++;
                for (int i = 0; i < NSLOTS; i++) begin
                    if (n < n_due && slot_due(i)) begin
                        tbl_stamp[i] = tick_now;
                        tx_total = tx_total + 1;
                        expected_beats.push_back(make_beat(K_RETX, tbl_id[i], i,
                                                           n == n_due - 1));
                        n++;
                    end
                end
            end
            default: begin
            end
        endcase
    endtask

    // monitor: check strobed beats, then log the command taken at this edge
    always @(posedge i_clk) begin
        beat_t got;
        beat_t want;
        if (!i_rst_n) begin
            beat_taken = 1'b0;
        end else begin
            if (o_strobe === 1'b1) begin
                got.kind = o_kind;
                got.msg_id = o_msg_id;
                got.slot = o_slot;
                got.count = o_transmit_count;
                got.last = o_last;
                if (expected_beats.size() == 0) begin
                    note_mismatch({"unexpected beat: ", beat_str(got)});
                end else begin
                    want = expected_beats.pop_front();
                    if (got.kind !== want.kind || got.msg_id !== want.msg_id ||
                        got.slot !== want.slot || got.count !== want.count ||
                        got.last !== want.last)
                        note_mismatch({"expected ", beat_str(want), ", got ", beat_str(got)});
                end
            end
            beat_taken = start && !busy;
            if (beat_taken) begin
                items_taken++;
                advance_table(i_func, i_ack_id);
            end
        end
    end

    // driver: holds start until taken, then waits out the drawn gap
    always @(negedge i_clk) begin
        op_item_t nxt;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (!start || beat_taken) begin
            if (gap_left > 0) begin
                start <= 1'b0;
                gap_left <= gap_left - 1;
            end else if (pending_ops.size() > 0) begin
                nxt = pending_ops.pop_front();
                start <= 1'b1;
                i_func <= nxt.func;
                i_ack_id <= nxt.ack_id;
                gap_left <= nxt.gap;
            end else begin
                start <= 1'b0;
            end
        end
    end

    task automatic queue_op(input logic [1:0] func, input logic [IdW-1:0] aid);
        op_item_t it;
        it.func = func;
        it.ack_id = aid;
        it.gap = steady ? 0 : $urandom_range(0, 7);
        pending_ops.push_back(it);
        items_queued++;
    endtask

    // wait until every command is taken and every beat is in, then let the
    // block finish any scan that gives no beat
    task automatic settle();
        int waited;
        waited = 0;
        while (items_taken != items_queued)
            @(negedge i_clk);
        while ((expected_beats.size() != 0 || busy !== 1'b0) && waited < DRAIN_LIMIT) begin
            @(negedge i_clk);
            waited++;
        end
        if (expected_beats.size() != 0) begin
            note_mismatch($sformatf("%0d beats never arrived", expected_beats.size()));
            error_count += expected_beats.size() - 1;
            expected_beats.delete();
        end
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_timeout(input logic [7:0] value);
        @(negedge i_clk);
        psel = 1'b1;
        pwrite = 1'b1;
        penable = 1'b0;
        paddr = TIMEOUT_ADDR;
        pwdata = {24'($urandom), value};
        @(negedge i_clk);
        penable = 1'b1;
        @(negedge i_clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        timeout_cfg = value;
    endtask

    initial begin
        logic [IdW-1:0] ack_pool [$];
        logic [IdW-1:0] gen_id;
        logic [7:0]     phase_timeout [PHASES];
        int             pick;
        int             idx;
        int             counted;
        phase_timeout = '{8'd1, 8'd3, 8'd0, 8'd255, 8'd2, 8'd1};
        phase_timeout[PHASES-1] = 8'($urandom_range(1, 254));
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // empty table, extreme ack ids, idle tick, undefined code
        queue_op(F_ACK, '0);
        queue_op(F_ACK, '1);
        queue_op(F_TICK, $urandom);
        queue_op(F_UNDEF, '1);
        // fill every slot, one more gives table full
        repeat (NSLOTS + 1) queue_op(F_SEND, $urandom);
        // second tick ages all sixteen entries to the reset timeout
        queue_op(F_TICK, $urandom);
        queue_op(F_TICK, $urandom);
        queue_op(F_ACK, 32'd5);
        queue_op(F_ACK, 32'd5);
        queue_op(F_SEND, $urandom);
        settle();

        // zero timeout: everything due on every tick
        write_timeout(8'd0);
        steady = 1'b1;
        queue_op(F_TICK, '0);
        queue_op(F_TICK, '0);
        queue_op(F_ACK, 32'd17);
        queue_op(F_SEND, '1);
        settle();

        for (int p = 0; p < PHASES; p++) begin
            ack_pool.delete();
            for (int i = 0; i < NSLOTS; i++)
                if (tbl_valid[i])
                    ack_pool.push_back(tbl_id[i]);
            gen_id = id_counter;
            write_timeout(phase_timeout[p]);
            steady = (p % 3 == 1);
            counted = 0;
            while (counted < PHASE_OPS) begin
                pick = $urandom_range(0, 99);
                if (pick < 35) begin
                    gen_id = gen_id + 1;
                    ack_pool.push_back(gen_id);
                    queue_op(F_SEND, $urandom);
                    counted++;
                end else if (pick < 60 && ack_pool.size() > 0) begin
                    idx = $urandom_range(0, ack_pool.size() - 1);
                    queue_op(F_ACK, ack_pool[idx]);
                    ack_pool.delete(idx);
                    counted++;
                end else if (pick < 68) begin
                    queue_op(F_ACK, $urandom);
                    counted++;
                end else if (pick < 95) begin
                    queue_op(F_TICK, $urandom);
                    counted++;
                end else begin
                    queue_op(F_UNDEF, $urandom);
                end
            end
            settle();
        end

        if (error_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial begin
        #4000000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
